FILE: rtl/core/mse_pkg.sv
// Shared types, codes and helpers for the multi-stack engine.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

	localparam int HANDLE_W  = 4;
	localparam int VALUE_W   = 64;
	localparam int BCNT_W    = 4;
	localparam int DEPTH_W   = 7;
	localparam int MAX_BYTES = 8;

	typedef enum logic [1:0] {
		REQ_NEW  = 2'd0,
		REQ_FREE = 2'd1,
		REQ_PUSH = 2'd2,
		REQ_POP  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_HANDLE = 3'd1,
		ST_BAD_SIZE   = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_FULL       = 3'd4,
		ST_NO_HANDLE  = 3'd5
	} status_t;

	typedef struct packed {
		req_kind_t           req_type;
		logic [HANDLE_W-1:0] handle;
		logic [VALUE_W-1:0]  push_value;
		logic [BCNT_W-1:0]   byte_count;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] new_handle;
		logic [VALUE_W-1:0]  popped_value;
		logic [BCNT_W-1:0]   popped_bytes;
		logic [DEPTH_W-1:0]  stack_depth;
		logic                handle_invalid;
	} rsp_t;

	typedef struct packed {
		logic [BCNT_W-1:0]  size;
		logic [VALUE_W-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic grant;
		logic release_stack;
		logic count_we;
	} tbl_cmd_t;

	function automatic logic [VALUE_W-1:0] byte_mask(input logic [BCNT_W-1:0] n);
		logic [VALUE_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (BCNT_W'(i) < n) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mse_entry_ram.sv
// Entry store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mse_entry_ram #(
	parameter int WORDS = 1024,
	parameter int AW    = 10,
	parameter int DW    = 68
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data_q
);

	logic [DW-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/mse_stack_table.sv
// Handle allocation, live flags and per-stack entry counts.
`timescale 1ns / 1ps
`default_nettype none
module mse_stack_table #(
	parameter int MAX_STACKS = 16,
	parameter int MAX_DEPTH  = 64,
	localparam int SIW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1,
	localparam int UW  = $clog2(MAX_STACKS + 1),
	localparam int CW  = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mse_pkg::tbl_cmd_t            cmd,
	input  wire logic [SIW-1:0]               cmd_idx,
	input  wire logic [CW-1:0]                cmd_count,
	input  wire logic [mse_pkg::HANDLE_W-1:0] chk_handle,
	output logic                              chk_ok,
	output logic      [UW-1:0]                used,
	input  wire logic [mse_pkg::HANDLE_W-1:0] look_handle,
	output logic      [CW-1:0]                look_count
);

	localparam int HCW = (UW > mse_pkg::HANDLE_W) ? UW : mse_pkg::HANDLE_W;

	logic [UW-1:0]         used_q;
	logic [MAX_STACKS-1:0] live_q;
	logic [CW-1:0]         count_q [MAX_STACKS];
	logic [SIW-1:0]        look_idx;

	assign used     = used_q;
	assign chk_ok   = (HCW'(chk_handle) < HCW'(used_q)) && live_q[SIW'(chk_handle)];
	assign look_idx = SIW'(look_handle);

	// forward the count being committed this cycle
	assign look_count = (cmd.count_we && (cmd_idx == look_idx)) ? cmd_count
	                                                           : count_q[look_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			live_q <= '0;
			for (int i = 0; i < MAX_STACKS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (cmd.grant) begin
				used_q                <= used_q + UW'(1);
				live_q[SIW'(used_q)]  <= 1'b1;
			end
			if (cmd.release_stack) begin
				live_q[cmd_idx] <= 1'b0;
			end
			if (cmd.count_we) begin
				count_q[cmd_idx] <= cmd_count;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/mse_exec.sv
// Request decision: status, result fields and state updates for one transaction.
`timescale 1ns / 1ps
`default_nettype none
module mse_exec #(
	parameter int MAX_STACKS = 16,
	parameter int MAX_DEPTH  = 64,
	localparam int UW = $clog2(MAX_STACKS + 1),
	localparam int CW = $clog2(MAX_DEPTH + 1)
) (
	input  wire mse_pkg::req_t     req,
	input  wire logic [CW-1:0]     cnt,
	input  wire mse_pkg::entry_t   top,
	input  wire logic              handle_ok,
	input  wire logic [UW-1:0]     used,
	output mse_pkg::rsp_t          rsp,
	output mse_pkg::tbl_cmd_t      cmd,
	output logic      [CW-1:0]     new_count,
	output logic                   push_we,
	output mse_pkg::entry_t        push_word
);

	logic size_ok;
	logic full;
	logic grant_ok;

	assign size_ok  = (req.byte_count != '0) &&
	                  (req.byte_count <= mse_pkg::BCNT_W'(mse_pkg::MAX_BYTES));
	assign full     = cnt >= CW'(MAX_DEPTH);
	assign grant_ok = used < UW'(MAX_STACKS);

	assign push_word.size  = req.byte_count;
	assign push_word.value = req.push_value & mse_pkg::byte_mask(req.byte_count);

	always_comb begin
		rsp       = '0;
		rsp.status = mse_pkg::ST_OK;
		cmd       = '0;
		new_count = cnt;
		push_we   = 1'b0;
		if (req.req_type != mse_pkg::REQ_NEW && !handle_ok) begin
			rsp.status         = mse_pkg::ST_BAD_HANDLE;
			rsp.handle_invalid = 1'b1;
		end else begin
			unique case (req.req_type)
				mse_pkg::REQ_NEW: begin
					new_count = '0;
					if (grant_ok) begin
						cmd.grant      = 1'b1;
						rsp.new_handle = mse_pkg::HANDLE_W'(used);
					end else begin
						rsp.status         = mse_pkg::ST_NO_HANDLE;
						rsp.handle_invalid = 1'b1;
					end
				end
				mse_pkg::REQ_FREE: begin
					cmd.release_stack  = 1'b1;
					cmd.count_we       = 1'b1;
					new_count          = '0;
					rsp.handle_invalid = 1'b1;
				end
				mse_pkg::REQ_PUSH: begin
					priority if (!size_ok) begin
						rsp.status = mse_pkg::ST_BAD_SIZE;
					end else if (full) begin
						rsp.status = mse_pkg::ST_FULL;
					end else begin
						push_we      = 1'b1;
						cmd.count_we = 1'b1;
						new_count    = cnt + CW'(1);
					end
				end
				mse_pkg::REQ_POP: begin
					priority if (!size_ok) begin
						rsp.status = mse_pkg::ST_BAD_SIZE;
					end else if (cnt == '0) begin
						rsp.status = mse_pkg::ST_EMPTY;
					end else if (top.size != req.byte_count) begin
						rsp.status = mse_pkg::ST_BAD_SIZE;
					end else begin
						rsp.popped_value = top.value;
						rsp.popped_bytes = req.byte_count;
						cmd.count_we     = 1'b1;
						new_count        = cnt - CW'(1);
					end
				end
			endcase
			rsp.stack_depth = mse_pkg::DEPTH_W'(new_count);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/multi_stack_engine_core.sv
// Top level of the multi-stack engine: input stage, entry store and result register.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------
//  request | req_valid/req_ready  | req_data  (mse_pkg::req_t)
//  result  | rsp_valid/rsp_ready  | rsp_data  (mse_pkg::rsp_t)
//
//  One transaction a cycle; each request passes the input stage, then the result register.
//  The top entry is read from the entry store at acceptance, with the count
//  forwarded from the transaction committing in the same cycle.
//  Reset clears handle allocation, live flags and counts; no clearing pass.
//  A stalled result holds the input stage; req_ready drops only then.
`timescale 1ns / 1ps
`default_nettype none
module multi_stack_engine_core #(
	parameter int MAX_STACKS = 16,
	parameter int MAX_DEPTH  = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mse_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output mse_pkg::rsp_t      rsp_data
);

	localparam int SIW   = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int UW    = $clog2(MAX_STACKS + 1);
	localparam int CW    = $clog2(MAX_DEPTH + 1);
	localparam int SLW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int WORDS = MAX_STACKS * MAX_DEPTH;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [AW-1:0] DEPTH_A = AW'(MAX_DEPTH);

	logic              valid_s1;
	mse_pkg::req_t     req_s1;
	logic [CW-1:0]     cnt_s1;
	logic              byp_s1;
	mse_pkg::entry_t   byp_word_s1;
	logic              out_valid_q;
	mse_pkg::rsp_t     out_q;

	logic              adv;
	logic              accept;
	logic              commit;
	logic [CW-1:0]     look_count;
	logic [SLW-1:0]    rd_slot;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;
	logic [mse_pkg::ENTRY_W-1:0] rd_data;
	mse_pkg::entry_t   top;
	logic              handle_ok;
	logic [UW-1:0]     used;
	mse_pkg::rsp_t     rsp;
	mse_pkg::tbl_cmd_t cmd;
	mse_pkg::tbl_cmd_t cmd_eff;
	logic [CW-1:0]     new_count;
	logic              push_we;
	mse_pkg::entry_t   push_word;
	logic [SIW-1:0]    idx_s1;

	assign adv       = !out_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;
	assign accept    = req_valid && req_ready;
	assign commit    = valid_s1 && adv;
	assign cmd_eff   = commit ? cmd : '0;
	assign wr_en     = commit && push_we;
	assign idx_s1    = SIW'(req_s1.handle);

	assign rd_slot = (look_count == '0) ? '0 : SLW'(look_count - CW'(1));
	assign rd_addr = AW'(SIW'(req_data.handle)) * DEPTH_A + AW'(rd_slot);
	assign wr_addr = AW'(idx_s1) * DEPTH_A + AW'(SLW'(cnt_s1));

	assign top = byp_s1 ? byp_word_s1 : mse_pkg::entry_t'(rd_data);

	mse_stack_table #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_eff),
		.cmd_idx    (idx_s1),
		.cmd_count  (new_count),
		.chk_handle (req_s1.handle),
		.chk_ok     (handle_ok),
		.used       (used),
		.look_handle(req_data.handle),
		.look_count (look_count)
	);

	mse_entry_ram #(
		.WORDS(WORDS),
		.AW   (AW),
		.DW   (mse_pkg::ENTRY_W)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (push_word),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.rd_data_q(rd_data)
	);

	mse_exec #(
		.MAX_STACKS(MAX_STACKS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_exec (
		.req      (req_s1),
		.cnt      (cnt_s1),
		.top      (top),
		.handle_ok(handle_ok),
		.used     (used),
		.rsp      (rsp),
		.cmd      (cmd),
		.new_count(new_count),
		.push_we  (push_we),
		.push_word(push_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// bypass the entry written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req_data;
			cnt_s1      <= look_count;
			byp_s1      <= wr_en && (wr_addr == rd_addr);
			byp_word_s1 <= push_word;
		end
		if (commit) begin
			out_q <= rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> req_ready)
		else $error("request stage blocked while result register is free");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cnt_s1 < CW'(MAX_DEPTH)))
		else $error("entry written to a full stack");

	a_invalid_no_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.handle_invalid |-> (out_q.stack_depth == '0))
		else $error("invalid handle reported with nonzero depth");

	a_commit_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(cmd.grant && (cmd.count_we || cmd.release_stack)))
		else $error("allocation combined with stack update");

endmodule
`default_nettype wire

FILE: tb/sv/multi_stack_engine_core_test.sv
// Self-checking testbench for the multi-stack engine: request driver, result checker and tracker.
`timescale 1ns / 1ps

localparam int N_STACKS    = 16;
localparam int STACK_DEPTH = 64;
localparam int LONG_HOLD   = 300;

class stack_bank_tracker;
	logic [4:0]                  handles_used;
	bit                          live [N_STACKS];
	logic [mse_pkg::DEPTH_W-1:0] depth_of [N_STACKS];
	logic [mse_pkg::VALUE_W-1:0] entry_val [N_STACKS][STACK_DEPTH];
	logic [mse_pkg::BCNT_W-1:0]  entry_len [N_STACKS][STACK_DEPTH];
	mse_pkg::rsp_t               pending_results [$];
	int                          errors;
	int                          checked;
	int                          status_seen [6];

	function new();
		handles_used = '0;
		errors = 0;
		checked = 0;
		foreach (live[i]) begin
			live[i] = 1'b0;
			depth_of[i] = '0;
		end
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	function bit usable(logic [mse_pkg::HANDLE_W-1:0] h);
		return ({1'b0, h} < handles_used) && live[h];
	endfunction

	function int live_total();
		int c;
		c = 0;
		for (int i = 0; i < N_STACKS; i++) begin
			if (usable(mse_pkg::HANDLE_W'(i))) c++;
		end
		return c;
	endfunction

	function logic [mse_pkg::VALUE_W-1:0] keep_bytes(logic [mse_pkg::BCNT_W-1:0] n);
		if (n >= mse_pkg::BCNT_W'(8)) return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function void note_request(mse_pkg::req_t r);
		mse_pkg::rsp_t               e;
		logic [mse_pkg::DEPTH_W-1:0] cnt;
		bit                          size_fine;
		e = '0;
		e.status = mse_pkg::ST_OK;
		cnt = depth_of[r.handle];
		size_fine = (r.byte_count >= mse_pkg::BCNT_W'(1)) &&
			(r.byte_count <= mse_pkg::BCNT_W'(mse_pkg::MAX_BYTES));
		if (r.req_type == mse_pkg::REQ_NEW) begin
			if (handles_used < N_STACKS) begin
				e.new_handle = handles_used[mse_pkg::HANDLE_W-1:0];
				live[handles_used[mse_pkg::HANDLE_W-1:0]] = 1'b1;
				depth_of[handles_used[mse_pkg::HANDLE_W-1:0]] = '0;
				handles_used++;
			end else begin
				e.status = mse_pkg::ST_NO_HANDLE;
				e.handle_invalid = 1'b1;
			end
		end else if (!usable(r.handle)) begin
			e.status = mse_pkg::ST_BAD_HANDLE;
			e.handle_invalid = 1'b1;
		end else if (r.req_type == mse_pkg::REQ_FREE) begin
			live[r.handle] = 1'b0;
			depth_of[r.handle] = '0;
			e.handle_invalid = 1'b1;
		end else begin
			if (!size_fine) begin
				e.status = mse_pkg::ST_BAD_SIZE;
			end else if (r.req_type == mse_pkg::REQ_PUSH) begin
				if (cnt >= STACK_DEPTH) begin
					e.status = mse_pkg::ST_FULL;
				end else begin
					entry_val[r.handle][cnt] = r.push_value & keep_bytes(r.byte_count);
					entry_len[r.handle][cnt] = r.byte_count;
					depth_of[r.handle] = cnt + 1'b1;
				end
			end else if (cnt == 0) begin
				e.status = mse_pkg::ST_EMPTY;
			end else if (entry_len[r.handle][cnt - 1'b1] != r.byte_count) begin
				e.status = mse_pkg::ST_BAD_SIZE;
			end else begin
				e.popped_value = entry_val[r.handle][cnt - 1'b1];
				e.popped_bytes = r.byte_count;
				depth_of[r.handle] = cnt - 1'b1;
			end
			e.stack_depth = depth_of[r.handle];
		end
		pending_results.push_back(e);
	endfunction

	function void compare(string field, logic [mse_pkg::VALUE_W-1:0] want,
			logic [mse_pkg::VALUE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endfunction

	function void check_result(mse_pkg::rsp_t got);
		mse_pkg::rsp_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request outstanding, status %0d", got.status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		status_seen[want.status]++;
		compare("status", want.status, got.status);
		compare("new_handle", want.new_handle, got.new_handle);
		compare("popped_value", want.popped_value, got.popped_value);
		compare("popped_bytes", want.popped_bytes, got.popped_bytes);
		compare("stack_depth", want.stack_depth, got.stack_depth);
		compare("handle_invalid", want.handle_invalid, got.handle_invalid);
	endfunction
endclass

module multi_stack_engine_core_test;
	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	mse_pkg::req_t     req_data;
	logic              rsp_valid;
	logic              rsp_ready;
	mse_pkg::rsp_t     rsp_data;
	stack_bank_tracker sb;
	int                sent;
	bit                hold_rsp;
	int                tx_calm;
	int                rx_calm;

	multi_stack_engine_core #(
		.MAX_STACKS(N_STACKS),
		.MAX_DEPTH (STACK_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic logic [mse_pkg::VALUE_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [mse_pkg::BCNT_W-1:0] legal_size();
		return mse_pkg::BCNT_W'($urandom_range(1, mse_pkg::MAX_BYTES));
	endfunction

	function automatic mse_pkg::req_t mk(mse_pkg::req_kind_t k,
			logic [mse_pkg::HANDLE_W-1:0] h, logic [mse_pkg::VALUE_W-1:0] v,
			logic [mse_pkg::BCNT_W-1:0] n);
		mse_pkg::req_t r;
		r.req_type = k;
		r.handle = h;
		r.push_value = v;
		r.byte_count = n;
		return r;
	endfunction

	function automatic int pick_live();
		int pool [$];
		for (int i = 0; i < N_STACKS; i++) begin
			if (sb.usable(mse_pkg::HANDLE_W'(i))) pool.push_back(i);
		end
		if (pool.size() == 0) return -1;
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	function automatic mse_pkg::req_t noise_request();
		mse_pkg::req_kind_t k;
		case ($urandom_range(0, 7))
			0: k = mse_pkg::REQ_FREE;
			1, 2, 3: k = mse_pkg::REQ_PUSH;
			default: k = mse_pkg::REQ_POP;
		endcase
		return mk(k, mse_pkg::HANDLE_W'($urandom), rand64(), mse_pkg::BCNT_W'($urandom));
	endfunction

	function automatic mse_pkg::req_t orderly_request();
		int                         h;
		int                         roll;
		logic [mse_pkg::BCNT_W-1:0] n;
		h = pick_live();
		roll = $urandom_range(0, 99);
		if (sb.handles_used < N_STACKS && (h < 0 || sb.live_total() < 3 || roll < 3))
			return mk(mse_pkg::REQ_NEW, mse_pkg::HANDLE_W'($urandom), rand64(),
				mse_pkg::BCNT_W'($urandom));
		if (h < 0) return noise_request();
		if (roll < 5 && sb.live_total() > 4)
			return mk(mse_pkg::REQ_FREE, mse_pkg::HANDLE_W'(h), rand64(),
				mse_pkg::BCNT_W'($urandom));
		if (roll < 60)
			return mk(mse_pkg::REQ_PUSH, mse_pkg::HANDLE_W'(h), rand64(), legal_size());
		if (sb.depth_of[h] != 0 && roll < 95) n = sb.entry_len[h][sb.depth_of[h] - 1'b1];
		else n = legal_size();
		return mk(mse_pkg::REQ_POP, mse_pkg::HANDLE_W'(h), rand64(), n);
	endfunction

	task automatic send(input mse_pkg::req_t r);
		int gap;
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		sent++;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) send(noise_request());
			else send(orderly_request());
		end
	endtask

	task automatic fill_phase();
		int h;
		h = pick_live();
		if (h < 0) begin
			send(mk(mse_pkg::REQ_NEW, '0, '0, '0));
			h = pick_live();
		end
		if (h < 0) return;
		hold_rsp = 1'b1;
		while (sb.depth_of[h] < STACK_DEPTH)
			send(mk(mse_pkg::REQ_PUSH, mse_pkg::HANDLE_W'(h), rand64(), legal_size()));
		repeat (3) send(mk(mse_pkg::REQ_PUSH, mse_pkg::HANDLE_W'(h), rand64(), legal_size()));
		send(mk(mse_pkg::REQ_PUSH, mse_pkg::HANDLE_W'(h), rand64(), mse_pkg::BCNT_W'(0)));
		repeat (12) send(mk(mse_pkg::REQ_POP, mse_pkg::HANDLE_W'(h), rand64(),
			sb.entry_len[h][sb.depth_of[h] - 1'b1]));
	endtask

	initial begin
		int gap;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_rsp) begin
				gap = LONG_HOLD;
				hold_rsp = 1'b0;
			end else begin
				gap = pick_gap(rx_calm);
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp_data);
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		sb = new();
		sent = 0;
		hold_rsp = 1'b0;
		tx_calm = 0;
		rx_calm = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(mse_pkg::REQ_NEW, 4'hF, '1, 4'hF));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd1));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, '1, 4'd1));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, '1, 4'd8));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, '1, 4'd0));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, '1, 4'd9));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, '1, 4'hF));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd0));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'hF));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd1));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd8));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd1));
		send(mk(mse_pkg::REQ_POP, 4'd0, '0, 4'd1));
		send(mk(mse_pkg::REQ_PUSH, 4'd1, rand64(), 4'd4));
		send(mk(mse_pkg::REQ_PUSH, 4'hF, rand64(), 4'd4));
		send(mk(mse_pkg::REQ_NEW, 4'd0, '0, 4'd0));
		send(mk(mse_pkg::REQ_PUSH, 4'd1, 64'hA5A5_A5A5_A5A5_A5A5, 4'd3));
		send(mk(mse_pkg::REQ_FREE, 4'd1, '0, 4'd0));
		send(mk(mse_pkg::REQ_PUSH, 4'd1, rand64(), 4'd2));
		send(mk(mse_pkg::REQ_POP, 4'd1, '0, 4'd3));
		send(mk(mse_pkg::REQ_FREE, 4'd1, '0, 4'd0));
		send(mk(mse_pkg::REQ_FREE, 4'hF, '0, 4'd0));
		send(mk(mse_pkg::REQ_PUSH, 4'd0, rand64(), 4'd5));
		drain();

		random_phase(160);
		fill_phase();
		random_phase(100);
		while (sb.handles_used < N_STACKS)
			send(mk(mse_pkg::REQ_NEW, mse_pkg::HANDLE_W'($urandom), rand64(), '0));
		repeat (3) send(mk(mse_pkg::REQ_NEW, mse_pkg::HANDLE_W'($urandom), rand64(),
			mse_pkg::BCNT_W'($urandom)));
		random_phase(100);
		for (int i = 0; i < N_STACKS; i++) begin
			if (sb.usable(mse_pkg::HANDLE_W'(i)))
				send(mk(mse_pkg::REQ_FREE, mse_pkg::HANDLE_W'(i), rand64(), '0));
		end
		for (int i = 0; i < N_STACKS; i++) begin
			send(mk($urandom_range(0, 1) ? mse_pkg::REQ_PUSH : mse_pkg::REQ_POP,
				mse_pkg::HANDLE_W'(i), rand64(), legal_size()));
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Run covered %0d requests, %0d results checked, %0d handles granted.",
			sent, sb.checked, sb.handles_used);
		$display("Outcomes: ok %0d, bad handle %0d, bad size %0d, empty %0d, full %0d, %s %0d",
			sb.status_seen[mse_pkg::ST_OK], sb.status_seen[mse_pkg::ST_BAD_HANDLE],
			sb.status_seen[mse_pkg::ST_BAD_SIZE], sb.status_seen[mse_pkg::ST_EMPTY],
			sb.status_seen[mse_pkg::ST_FULL], "none left",
			sb.status_seen[mse_pkg::ST_NO_HANDLE]);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
